### hw/rtl/stxfb_pkg.sv
// Shared types and constants for the STX / length / LRC frame builder.
package stxfb_pkg;

    localparam logic [7:0]  STX_BYTE = 8'h02;
    localparam logic [15:0] MIN_BODY = 16'd3;

    // Queue sizing between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Entry kinds: frame opener, plain body byte, frame closer
    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_MID   = 2'd1;
    localparam logic [1:0] KIND_LAST  = 2'd2;

    // Sub-step indexes within one entry's output burst
    localparam logic [1:0] SUB_0 = 2'd0;
    localparam logic [1:0] SUB_1 = 2'd1;
    localparam logic [1:0] SUB_2 = 2'd2;
    localparam logic [1:0] SUB_3 = 2'd3;

    // One classified item: aux holds the length (opener) or the LRC (closer)
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] aux;
    } entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hw/rtl/stxfb_front.sv
// Front end: accepts body bytes, tracks frame state and the running LRC.
module stxfb_front
    import stxfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] body_byte, [23:8] body_length
    input  q_status_t   q_status,
    output logic        push,
    output entry_t      push_entry
);

    logic        in_frame_reg, in_frame_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  lrc_reg, lrc_next;

    logic [7:0]  body_byte;
    logic [15:0] body_length;
    logic [15:0] len_fixed;
    logic [15:0] left_dec;
    logic [7:0]  lrc_mid;

    assign body_byte   = s_tdata[7:0];
    assign body_length = s_tdata[23:8];
    assign s_tready    = !q_status.full;
    assign push        = s_tvalid && s_tready;

    // Classify the item and work out the next frame state
    always_comb
    begin
        len_fixed  = (body_length < MIN_BODY) ? MIN_BODY : body_length;
        left_dec   = (bytes_left_reg != 16'd0) ? (bytes_left_reg - 16'd1) : bytes_left_reg;
        lrc_mid    = lrc_reg ^ body_byte;

        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        lrc_next        = lrc_reg;

        push_entry.data = body_byte;
        push_entry.kind = KIND_MID;
        push_entry.aux  = 16'd0;

        if (!in_frame_reg)
        begin
            push_entry.kind = KIND_FIRST;
            push_entry.aux  = len_fixed;
            if (push)
            begin
                in_frame_next   = 1'b1;
                bytes_left_next = len_fixed - 16'd1;
                lrc_next        = len_fixed[15:8] ^ len_fixed[7:0] ^ body_byte;
            end
        end
        else if (left_dec == 16'd0)
        begin
            push_entry.kind = KIND_LAST;
            push_entry.aux  = {8'd0, lrc_mid};
            if (push)
            begin
                in_frame_next   = 1'b0;
                bytes_left_next = 16'd0;
                lrc_next        = 8'd0;
            end
        end
        else if (push)
        begin
            bytes_left_next = left_dec;
            lrc_next        = lrc_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 16'd0;
            lrc_reg        <= 8'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            lrc_reg        <= lrc_next;
        end
    end

endmodule

### hw/rtl/stxfb_queue.sv
// Short queue of classified entries between front and back.
module stxfb_queue
    import stxfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_status
);

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;

    assign head           = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/stxfb_back.sv
// Back end: expands each queued entry into its output bytes.
module stxfb_back
    import stxfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic      m_tlast,    // run_last
    output logic      m_tuser     // [0] frame_end
);

    logic [1:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       end_reg;

    logic       load;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       sel_end;

    assign load     = !q_status.empty && (!valid_reg || m_tready);
    assign pop      = load && sel_last;
    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = end_reg;

    // Pick the byte for the current sub-step of the head entry
    always_comb
    begin
        sel_byte = head.data;
        sel_last = 1'b1;
        sel_end  = 1'b0;
        case (head.kind)
            KIND_FIRST:
            begin
                sel_last = (sub_reg == SUB_3);
                case (sub_reg)
                    SUB_0:   sel_byte = STX_BYTE;
                    SUB_1:   sel_byte = head.aux[15:8];
                    SUB_2:   sel_byte = head.aux[7:0];
                    default: sel_byte = head.data;
                endcase
            end
            KIND_LAST:
            begin
                sel_last = (sub_reg == SUB_1);
                sel_end  = (sub_reg == SUB_1);
                sel_byte = (sub_reg == SUB_1) ? head.aux[7:0] : head.data;
            end
            default:
            begin
                sel_byte = head.data;
            end
        endcase

        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = sel_last ? SUB_0 : sub_reg + 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= SUB_0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            last_reg <= sel_last;
            end_reg  <= sel_end;
        end
    end

endmodule

### hw/rtl/stx_length_lrc_frame_builder_core.sv
// Top level of the STX / length / LRC frame builder.
//
// Input stream (s_*): one body byte per transfer. The first transfer of a
// frame also carries the 16-bit body length (values below 3 are raised to
// 3); later transfers ignore it.
// Output stream (m_*): framed bytes: 0x02, length high, length low, body
// bytes, then the XOR LRC over the length and body bytes. m_tuser flags the
// LRC byte, m_tlast marks the last byte caused by each input transfer.
// The first output byte of an input transfer is registered in the queue
// and then in the output register.
// Throughput: the input takes one transfer per cycle while the 4-entry queue
// has room; the output emits one byte per cycle while m_tready is high. A
// frame's opener gives 4 output bytes, each middle byte 1, the closer 2. The
// output byte rate is the limit; the queue absorbs header and trailer bursts.
// Reset clears frame state, queue and output valid; the next byte opens a
// new frame. When the receiver stalls, the output register holds, the queue
// fills, and s_tready drops once it is full.
module stx_length_lrc_frame_builder_core
    import stxfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] body_byte, [23:8] body_length
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] frame_end
);

    q_status_t q_status;
    entry_t    push_entry;
    entry_t    head;
    logic      push;
    logic      pop;

    stxfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    stxfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    stxfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### hw/rtl/stxfb_checker.sv
// Port-level checks for the frame builder, bound to the top level.
module stxfb_checker
    import stxfb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // Set after reset or after an LRC transfer: next output is a start byte
    logic expect_stx_reg;
    logic m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_stx_reg <= 1'b1;
        end
        else if (m_xfer)
        begin
            expect_stx_reg <= m_tuser;
        end
    end

    // Stalled output stays valid
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // Stalled output payload holds
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // LRC byte always closes the run of its input transfer
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("LRC byte without run end");

    // Every frame opens with a start byte that is not the end of a run
    a_frame_opens_stx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && expect_stx_reg |-> (m_tdata == STX_BYTE) && !m_tlast && !m_tuser)
        else $error("frame does not open with start byte");

endmodule

bind stx_length_lrc_frame_builder_core stxfb_checker u_stxfb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### tb/tb_stx_length_lrc_frame_builder_core.sv
// Self-checking testbench for the STX / length / XOR-LRC frame builder.
module tb_stx_length_lrc_frame_builder_core;
    import stxfb_pkg::*;

    // One framed output byte as seen on the master side
    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       run_last;
    } framed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] body_byte, [23:8] body_length
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] out_byte
    logic        m_tlast;
    logic        m_tuser;        // [0] frame_end

    // Body words waiting to be sent, framed bytes waiting to arrive
    logic [23:0]  body_words[$];
    framed_byte_t framed_bytes[$];

    // Shadow frame state
    logic        open_frame = 1'b0;
    logic [15:0] body_remain = '0;
    logic [7:0]  lrc_sum = '0;

    int send_idle = 0;
    int recv_idle = 0;
    bit send_hold = 1'b0;
    int words_queued = 0;
    int fail_count = 0;

    stx_length_lrc_frame_builder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the framed bytes one accepted body word produces
    function automatic void predict_framed_bytes(input logic [23:0] word);
        logic [7:0]  body;
        logic [15:0] len;
        body = word[7:0];
        len  = word[23:8];
        if (!open_frame)
        begin
            if (len < MIN_BODY)
                len = MIN_BODY;
            framed_bytes.push_back('{STX_BYTE, 1'b0, 1'b0});
            framed_bytes.push_back('{len[15:8], 1'b0, 1'b0});
            framed_bytes.push_back('{len[7:0], 1'b0, 1'b0});
            framed_bytes.push_back('{body, 1'b0, 1'b1});
            lrc_sum     = len[15:8] ^ len[7:0] ^ body;
            body_remain = len - 16'd1;
            open_frame  = 1'b1;
        end
        else
        begin
            lrc_sum = lrc_sum ^ body;
            if (body_remain != 16'd0)
                body_remain = body_remain - 16'd1;
            if (body_remain == 16'd0)
            begin
                framed_bytes.push_back('{body, 1'b0, 1'b0});
                framed_bytes.push_back('{lrc_sum, 1'b1, 1'b1});
                open_frame = 1'b0;
                lrc_sum    = '0;
            end
            else
            begin
                framed_bytes.push_back('{body, 1'b0, 1'b1});
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Driver: present queued body words, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_framed_bytes(s_tdata);
                void'(body_words.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (body_words.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= body_words[0];
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        framed_byte_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (framed_bytes.size() == 0)
                begin
                    report_mismatch("unexpected byte", m_tdata, 8'h00);
                end
                else
                begin
                    want = framed_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch("out_byte", m_tdata, want.data);
                    if (m_tuser !== want.frame_end)
                        report_mismatch("frame_end", {7'd0, m_tuser}, {7'd0, want.frame_end});
                    if (m_tlast !== want.run_last)
                        report_mismatch("run_last", {7'd0, m_tlast}, {7'd0, want.run_last});
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Queue one frame; later words carry junk in the ignored length field
    task automatic add_frame(input logic [15:0] len_field, input bit extreme_bytes);
        int count;
        logic [7:0] body;
        count = (len_field < MIN_BODY) ? int'(MIN_BODY) : int'(len_field);
        for (int i = 0; i < count; i++)
        begin
            if (extreme_bytes)
                body = (i % 2 == 0) ? 8'hFF : 8'h00;
            else
                body = 8'($urandom_range(255));
            if (i == 0)
                body_words.push_back({len_field, body});
            else
                body_words.push_back({16'($urandom_range(65535)), body});
            words_queued++;
        end
    endtask

    task automatic add_random_frames(input int target);
        int pick;
        logic [15:0] len;
        while (words_queued < target)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                len = 16'($urandom_range(2));
            else if (pick == 1)
                len = 16'($urandom_range(40, 13));
            else
                len = 16'($urandom_range(12, 3));
            add_frame(len, 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (body_words.size() > 0 || s_tvalid || framed_bytes.size() > 0)
            @(negedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles lightly, receiver heavily
        send_idle = 30;
        recv_idle = 70;
        // Short lengths raised to three, minimum and just above, extreme bytes
        add_frame(16'h0000, 1'b1);
        add_frame(16'h0001, 1'b0);
        add_frame(16'h0002, 1'b1);
        add_frame(16'h0003, 1'b1);
        add_frame(16'h0004, 1'b0);
        add_frame(16'h0005, 1'b1);
        add_random_frames(60);
        // Hold the sender until every pending byte has come out
        while (body_words.size() > 0 || s_tvalid)
            @(negedge clk);
        send_hold = 1'b1;
        while (framed_bytes.size() > 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        send_hold = 1'b0;
        add_random_frames(100);
        wait_drained();

        // Sender idles heavily, receiver lightly
        send_idle = 70;
        recv_idle = 30;
        add_random_frames(170);
        wait_drained();

        // No idling
        send_idle = 0;
        recv_idle = 0;
        add_random_frames(200);
        wait_drained();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_stx_length_lrc_frame_builder_core OK");
        else
            $display("tb_stx_length_lrc_frame_builder_core NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_stx_length_lrc_frame_builder_core NOT OK");
        $finish;
    end

endmodule
